### hdl/fpc_pkg.sv
package fpc_pkg;

    localparam int C_NUM_PLANES = 6;
    localparam int C_IDX_W      = 3;
    localparam int C_COORD_W    = 16;
    localparam int C_RAD_W      = 15;
    localparam int C_PLANE_W    = 64;
    localparam int C_PROD_W     = 2 * C_COORD_W;
    localparam int C_OFF_W      = C_COORD_W + 2;
    localparam int C_NORM_FRAC  = 14;
    localparam int C_SUM_W      = 36;

    // Planes tested by box queries: left, right, near, far
    localparam logic [C_NUM_PLANES-1:0] C_BOX_USE = 6'b110011;

    localparam logic ACT_BOX    = 1'b0;
    localparam logic ACT_SPHERE = 1'b1;

    typedef logic [2:0][C_COORD_W-1:0] t_vec3;

    typedef struct packed {
        logic               action;
        t_vec3              box_min;
        t_vec3              box_max;
        t_vec3              ball;
        logic [C_RAD_W-1:0] radius;
        logic               hit;
    } t_query;

endpackage

### hdl/fpc_cell.sv
module fpc_cell import fpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_cfg_we,
    input  logic [C_PLANE_W-1:0] i_cfg_data,
    input  logic                 i_box_use,
    input  logic                 i_vld,
    input  t_query               i_q,
    output logic                 o_vld,
    output t_query               o_q
);

    logic [C_PLANE_W-1:0] r_plane;

    logic                             r_a_vld;
    t_query                           r_a_q;
    logic signed [2:0][C_PROD_W-1:0]  r_prod;
    logic        [C_OFF_W-1:0]        r_off;
    logic                             r_en;

    logic   r_b_vld;
    t_query r_b_q;

    logic signed [C_COORD_W-1:0] w_nrm   [3];
    logic signed [C_COORD_W-1:0] w_coord [3];
    logic        [C_PROD_W-1:0]  w_prod  [3];
    logic        [C_COORD_W-1:0] w_dist;
    logic        [C_OFF_W-1:0]   w_off;
    logic                        w_sphere;
    logic        [C_SUM_W-1:0]   w_sum;
    t_query                      w_b_q;

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            if (!i_rst_n) begin
                r_plane <= '0;
            end else begin
                r_plane <= i_cfg_data;
            end
        end else if (!i_rst_n) begin
            r_plane <= '0;
        end
    end

    always_comb begin
        w_sphere = (i_q.action == ACT_SPHERE);
        w_dist   = r_plane[3*C_COORD_W +: C_COORD_W];
        for (int a = 0; a < 3; a++) begin
            w_nrm[a] = $signed(r_plane[a*C_COORD_W +: C_COORD_W]);
            if (w_sphere) begin
                w_coord[a] = $signed(i_q.ball[a]);
            end else if (w_nrm[a][C_COORD_W-1]) begin
                w_coord[a] = $signed(i_q.box_min[a]);
            end else begin
                w_coord[a] = $signed(i_q.box_max[a]);
            end
            w_prod[a] = C_PROD_W'(
                $signed({{C_COORD_W{w_nrm[a][C_COORD_W-1]}}, w_nrm[a]})
              * $signed({{C_COORD_W{w_coord[a][C_COORD_W-1]}}, w_coord[a]}));
        end
        w_off = {{2{w_dist[C_COORD_W-1]}}, w_dist}
              + (w_sphere ? {3'b000, i_q.radius} : C_OFF_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_adv) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_q <= i_q;
            for (int a = 0; a < 3; a++) begin
                r_prod[a] <= w_prod[a];
            end
            r_off <= w_off;
            r_en  <= w_sphere | i_box_use;
        end
    end

    always_comb begin
        w_sum = {{(C_SUM_W-C_PROD_W){r_prod[0][C_PROD_W-1]}}, r_prod[0]}
              + {{(C_SUM_W-C_PROD_W){r_prod[1][C_PROD_W-1]}}, r_prod[1]}
              + {{(C_SUM_W-C_PROD_W){r_prod[2][C_PROD_W-1]}}, r_prod[2]}
              + {{(C_SUM_W-C_OFF_W-C_NORM_FRAC){r_off[C_OFF_W-1]}}, r_off,
                 {C_NORM_FRAC{1'b0}}};
        w_b_q     = r_a_q;
        w_b_q.hit = r_a_q.hit & ~(r_en & w_sum[C_SUM_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_adv) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_q <= w_b_q;
        end
    end

    assign o_vld = r_b_vld;
    assign o_q   = r_b_q;

endmodule

### hdl/frustum_plane_cull_test_core.sv
// Frustum cull test: each word on the slave stream is a box query (tuser 0, tested
// against the left, right, near and far planes) or a sphere query (tuser 1, tested
// against all six planes); the master stream returns one word per query with bit 0
// set when the item may lie inside the frustum and clear when it is culled. Planes
// are written through the config channel (index 0..5: left, right, bottom, top,
// near, far); the user must write them only while no query is in flight, as the
// core does not enforce it. Writes to other indexes are dropped. The core takes
// one query per cycle unless a master-side stall holds the whole chain, and answers
// in order via six plane cells, each with a multiply and a sum-and-compare stage.
module frustum_plane_cull_test_core import fpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [C_IDX_W-1:0]   i_cfg_index,
    input  logic [C_PLANE_W-1:0] i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // ball_x, ball_y, ball_z (16 each), ball_radius (15), one zero pad bit
    input  logic [159:0]         s_axis_tdata,
    // action
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // intersects, seven zero pad bits
    output logic [7:0]           m_axis_tdata
);

    logic                    w_adv;
    logic                    w_vld [C_NUM_PLANES+1];
    t_query                  w_q   [C_NUM_PLANES+1];

    assign o_cfg_ready   = 1'b1;
    assign w_adv         = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = w_adv;

    always_comb begin
        w_vld[0]          = s_axis_tvalid;
        w_q[0].action     = s_axis_tuser;
        for (int a = 0; a < 3; a++) begin
            w_q[0].box_min[a] = s_axis_tdata[a*C_COORD_W +: C_COORD_W];
            w_q[0].box_max[a] = s_axis_tdata[(3+a)*C_COORD_W +: C_COORD_W];
            w_q[0].ball[a]    = s_axis_tdata[(6+a)*C_COORD_W +: C_COORD_W];
        end
        w_q[0].radius     = s_axis_tdata[9*C_COORD_W +: C_RAD_W];
        w_q[0].hit        = 1'b1;
    end

    for (genvar k = 0; k < C_NUM_PLANES; k++) begin : g_cell
        fpc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_cfg_we   (i_cfg_valid && (i_cfg_index == C_IDX_W'(k))),
            .i_cfg_data (i_cfg_data),
            .i_box_use  (C_BOX_USE[k]),
            .i_vld      (w_vld[k]),
            .i_q        (w_q[k]),
            .o_vld      (w_vld[k+1]),
            .o_q        (w_q[k+1])
        );
    end

    assign m_axis_tvalid = w_vld[C_NUM_PLANES];
    assign m_axis_tdata  = {7'b0000000, w_q[C_NUM_PLANES].hit};

endmodule

### hdl/fpc_checker.sv
module fpc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [7:0]   m_axis_tdata,
    input logic         o_cfg_ready
);

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
        else $error("output pad bits not zero");

    a_chain_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow chain advance");

    a_cfg_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config channel not ready");

endmodule

bind frustum_plane_cull_test_core fpc_checker u_fpc_checker (.*);

### sim/frustum_plane_cull_test_core_test.sv
module frustum_plane_cull_test_core_test import fpc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [C_IDX_W-1:0] PLANE_LEFT    = 3'd0;
    localparam logic [C_IDX_W-1:0] PLANE_RIGHT   = 3'd1;
    localparam logic [C_IDX_W-1:0] PLANE_BOTTOM  = 3'd2;
    localparam logic [C_IDX_W-1:0] PLANE_TOP     = 3'd3;
    localparam logic [C_IDX_W-1:0] PLANE_NEAR    = 3'd4;
    localparam logic [C_IDX_W-1:0] PLANE_FAR     = 3'd5;
    localparam logic [C_IDX_W-1:0] SPARE_INDEX_A = 3'd6;
    localparam logic [C_IDX_W-1:0] SPARE_INDEX_B = 3'd7;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic               action;
        t_vec3              box_min;
        t_vec3              box_max;
        t_vec3              ball;
        logic [C_RAD_W-1:0] radius;
    } t_cull_query;

    typedef logic [C_PLANE_W-1:0] t_plane_set [C_NUM_PLANES];

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [C_IDX_W-1:0]   i_cfg_index   = '0;
    logic [C_PLANE_W-1:0] i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [159:0]         s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;

    logic [C_PLANE_W-1:0] plane_regs [C_NUM_PLANES] = '{default: '0};
    logic                 intersect_q [$];

    int tx_idle_pct = 16;
    int rx_idle_pct = 79;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int cycle_count = 0;
    int errors      = 0;
    int n_box       = 0;
    int n_sphere    = 0;
    int n_culled    = 0;
    int n_writes    = 0;

    frustum_plane_cull_test_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("frustum_plane_cull_test_core_test: FAIL");
            $finish;
        end
    end

    // output side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (intersect_q.size() == 0) begin
                $error("intersects: word %0b arrived with nothing expected", m_axis_tdata[0]);
                errors++;
            end else begin
                logic want;
                want = intersect_q.pop_front();
                if (m_axis_tdata[0] !== want) begin
                    $error("intersects mismatch: expected %0b, actual %0b", want,
                           m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[0] === 1'b0)
                    n_culled++;
            end
        end
    end

    function automatic longint sx16(logic [15:0] v);
        return longint'($signed(v));
    endfunction

    // Q.18 signed distance of a Q11.4 point to a packed plane
    function automatic longint signed_offset(logic [C_PLANE_W-1:0] p, longint x, longint y,
                                             longint z);
        return sx16(p[15:0]) * x + sx16(p[31:16]) * y + sx16(p[47:32]) * z
             + (sx16(p[63:48]) <<< C_NORM_FRAC);
    endfunction

    function automatic logic predict_intersects(t_cull_query q);
        logic [C_PLANE_W-1:0] p;
        longint pick [3];
        longint reach;
        logic hit;
        hit   = 1'b1;
        reach = longint'(q.radius) <<< C_NORM_FRAC;
        for (int k = 0; k < C_NUM_PLANES; k++) begin
            p = plane_regs[k];
            if (q.action == ACT_BOX) begin
                if (k != PLANE_BOTTOM && k != PLANE_TOP) begin
                    for (int a = 0; a < 3; a++)
                        pick[a] = (sx16(p[16*a +: 16]) >= 0) ? sx16(q.box_max[a])
                                                             : sx16(q.box_min[a]);
                    if (signed_offset(p, pick[0], pick[1], pick[2]) < 0)
                        hit = 1'b0;
                end
            end else begin
                if (signed_offset(p, sx16(q.ball[0]), sx16(q.ball[1]), sx16(q.ball[2]))
                        < -reach)
                    hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic logic [15:0] rand_coord();
        int v;
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        v = int'($urandom_range(4095)) - 2048;
        return 16'(v);
    endfunction

    function automatic t_cull_query rand_query();
        t_cull_query q;
        logic [15:0] lo;
        logic [15:0] hi;
        q.action = 1'($urandom_range(1));
        for (int a = 0; a < 3; a++) begin
            lo = rand_coord();
            hi = rand_coord();
            if ($signed(lo) > $signed(hi) && $urandom_range(9) < 8) begin
                q.box_min[a] = hi;
                q.box_max[a] = lo;
            end else begin
                q.box_min[a] = lo;
                q.box_max[a] = hi;
            end
            q.ball[a] = rand_coord();
        end
        q.radius = ($urandom_range(3) == 0) ? C_RAD_W'($urandom)
                                            : C_RAD_W'($urandom_range(1023));
        return q;
    endfunction

    function automatic logic [15:0] rand_normal_part();
        int v;
        case ($urandom_range(7))
            0: return 16'h0000;
            1, 2: return 16'($urandom);
            default: begin
                v = int'($urandom_range(32768)) - 16384;
                return 16'(v);
            end
        endcase
    endfunction

    function automatic logic [C_PLANE_W-1:0] rand_plane();
        logic [15:0] d;
        int v;
        case ($urandom_range(2))
            0: d = 16'($urandom);
            1: d = 16'($urandom_range(32767, 8192));
            default: begin
                v = int'($urandom_range(4095)) - 2048;
                d = 16'(v);
            end
        endcase
        return {d, rand_normal_part(), rand_normal_part(), rand_normal_part()};
    endfunction

    function automatic t_cull_query make_box(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                                             logic [15:0] mx, logic [15:0] my,
                                             logic [15:0] mz);
        t_cull_query q;
        q         = rand_query();
        q.action  = ACT_BOX;
        q.box_min = {nz, ny, nx};
        q.box_max = {mz, my, mx};
        return q;
    endfunction

    function automatic t_cull_query make_ball(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                              logic [C_RAD_W-1:0] r);
        t_cull_query q;
        q        = rand_query();
        q.action = ACT_SPHERE;
        q.ball   = {z, y, x};
        q.radius = r;
        return q;
    endfunction

    task automatic send_query(t_cull_query q);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= q.action;
        s_axis_tdata  <= {1'b0, q.radius, q.ball, q.box_max, q.box_min};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        intersect_q.push_back(predict_intersects(q));
        if (q.action == ACT_BOX)
            n_box++;
        else
            n_sphere++;
    endtask

    // stop offering and wait until every expected word has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (intersect_q.size() != 0);
    endtask

    task automatic write_plane(logic [C_IDX_W-1:0] idx, logic [C_PLANE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx < C_NUM_PLANES)
            plane_regs[idx] = val;
        n_writes++;
    endtask

    task automatic set_planes(t_plane_set vals);
        drain();
        for (int k = 0; k < C_NUM_PLANES; k++)
            write_plane(C_IDX_W'(k), vals[k]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_query(make_box(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_query(make_ball(16'h8000, 16'h7FFF, 16'h0000, 15'h7FFF));
    endtask

    task automatic test_box_corners();
        t_plane_set vals;
        vals = '{
            {16'h0010, 16'h0000, 16'h0000, 16'h4000},
            {16'h0040, 16'h0000, 16'h0000, 16'hC000},
            {16'h0000, 16'h0000, 16'h4000, 16'h0000},
            {16'h0000, 16'h0000, 16'hC000, 16'h0000},
            {16'h0000, 16'h4000, 16'h0000, 16'h0000},
            {16'h7FFF, 16'hC000, 16'hE000, 16'h2000}
        };
        set_planes(vals);
        send_query(make_box(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_query(make_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_query(make_box(16'hF9C0, 16'h0000, 16'h0010, 16'hFCE0, 16'h0010, 16'h0020));
        // inverted on x: corners used as given
        send_query(make_box(16'h0100, 16'h0000, 16'h0000, 16'hFF00, 16'h0010, 16'h0010));
        send_query(make_box(16'h0050, 16'h0000, 16'h0000, 16'h0060, 16'h0010, 16'h0010));
        send_query(make_box(16'h0000, 16'h0000, 16'hFF38, 16'h0010, 16'h0010, 16'hFFFF));
        // max corner exactly on the left plane
        send_query(make_box(16'hFFE0, 16'h0000, 16'h0000, 16'hFFF0, 16'h0010, 16'h0010));
        send_query(make_ball(16'h0000, 16'h0000, 16'h0000, 15'h0000));
        send_query(make_ball(16'h0000, 16'hFFFF, 16'h0000, 15'h0000));
        send_query(make_ball(16'h0000, 16'hFFFF, 16'h0000, 15'h0001));
        send_query(make_ball(16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF));
        send_query(make_ball(16'h8000, 16'h8000, 16'h8000, 15'h7FFF));
    endtask

    task automatic test_extreme_planes();
        t_plane_set vals;
        vals = '{
            64'h8000_8000_8000_8000,
            64'h7FFF_7FFF_7FFF_7FFF,
            64'hFFFF_FFFF_FFFF_FFFF,
            64'h0000_0000_0000_0000,
            64'h7FFF_8000_7FFF_8000,
            64'h8000_7FFF_8000_7FFF
        };
        set_planes(vals);
        send_query(make_box(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_query(make_box(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000));
        send_query(make_ball(16'h8000, 16'h8000, 16'h8000, 15'h0000));
        send_query(make_ball(16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF));
    endtask

    task automatic test_ignored_index();
        drain();
        write_plane(SPARE_INDEX_A, 64'h0000_0000_0000_0000);
        write_plane(SPARE_INDEX_B, 64'hFFFF_FFFF_FFFF_FFFF);
        i_cfg_valid <= 1'b0;
        send_query(make_box(16'h0000, 16'h0000, 16'h0000, 16'h0010, 16'h0010, 16'h0010));
        send_query(make_ball(16'h0000, 16'h0000, 16'h0000, 15'h0010));
    endtask

    task automatic test_backpressure();
        t_plane_set vals;
        tx_idle_pct = 0;
        for (int k = 0; k < C_NUM_PLANES; k++)
            vals[k] = rand_plane();
        set_planes(vals);
        hold_req++;
        repeat (64) send_query(rand_query());
        drain();
        tx_idle_pct = 16;
    endtask

    task automatic test_random_stream(int tx_pct, int rx_pct);
        t_plane_set vals;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (4) begin
            for (int k = 0; k < C_NUM_PLANES; k++)
                vals[k] = rand_plane();
            set_planes(vals);
            repeat (84) send_query(rand_query());
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_box_corners();
        test_extreme_planes();
        test_ignored_index();
        test_backpressure();
        test_random_stream(16, 79);
        test_random_stream(79, 16);
        test_random_stream(0, 0);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (intersect_q.size() != 0)
            $error("intersects: %0d expected words never arrived", intersect_q.size());
        $display("covered %0d box and %0d sphere queries (%0d culled) over %0d plane writes",
                 n_box, n_sphere, n_culled, n_writes);
        $display("idle mixes 16/79, 79/16 and 0/0 plus a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (errors == 0 && intersect_q.size() == 0) begin
            $display("frustum_plane_cull_test_core_test: PASS");
        end else begin
            $display("frustum_plane_cull_test_core_test: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/fpc_pkg.sv
hdl/fpc_cell.sv
hdl/frustum_plane_cull_test_core.sv
hdl/fpc_checker.sv
sim/frustum_plane_cull_test_core_test.sv
